@@ rtl/dnd_pkg.sv @@
package dnd_pkg;

  localparam logic [7:0] PTR_MARK = 8'hc0;
  localparam logic [7:0] LOW_SIX  = 8'h3f;
  localparam logic [7:0] DOT_CHAR = 8'h2e;
  localparam int         PTR_W    = 14;
  localparam logic       FUNC_LOAD   = 1'b0;
  localparam logic       FUNC_DECODE = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [8:0] start_offset;
  } in_word_t;

  typedef struct packed {
    logic [63:0] name_chars;
    logic [3:0]  char_count;
    logic        last_chunk;
    logic        status;
    logic [9:0]  next_offset;
  } out_word_t;

  typedef struct packed {
    logic     vld;
    in_word_t word;
  } queue_t;

endpackage

@@ rtl/dns_name_decompressor_top.sv @@
// Load words: one per cycle while the engine is idle, through a four-entry queue into the engine.
// Decode words: the label walk uses the registered message memory, copying each
// name byte into the name memory and following labels and pointers, then emits
// the name's characters in chunks of up to eight, gated by the output register.
// Reset (rst_n low, synchronous) clears queue, state, message length, load
// position and sets max_name_length to 256; memories are not cleared.
module dns_name_decompressor_top #(
  parameter int MSG_BYTES  = 512,
  parameter int NAME_BYTES = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dnd_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output dnd_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [8:0]         cfg_wdata
);
  import dnd_pkg::*;

  queue_t     q;
  logic       q_pop;
  logic [8:0] max_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) max_len_r <= 9'd256;
    else if (cfg_we) max_len_r <= cfg_wdata;
  end

  dnd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q        (q),
    .q_pop    (q_pop)
  );

  dnd_engine #(
    .MSG_BYTES  (MSG_BYTES),
    .NAME_BYTES (NAME_BYTES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q         (q),
    .q_pop     (q_pop),
    .max_len   (max_len_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

@@ rtl/dnd_front.sv @@
module dnd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dnd_pkg::in_word_t in_word,
  output dnd_pkg::queue_t   q,
  input  logic              q_pop
);
  import dnd_pkg::*;

  in_word_t   fifo_r [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_stall = (cnt_r == 3'd4);
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && (cnt_r != 3'd0);
  assign q.vld    = (cnt_r != 3'd0);
  assign q.word   = fifo_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 2'd1 : wp_r;
    rp_nxt  = pop ? rp_r + 2'd1 : rp_r;
    cnt_nxt = cnt_r + {2'b0, push} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= in_word;
  end

endmodule

@@ rtl/dnd_engine.sv @@
module dnd_engine #(
  parameter int MSG_BYTES  = 512,
  parameter int NAME_BYTES = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dnd_pkg::queue_t    q,
  output logic               q_pop,
  input  logic [8:0]         max_len,
  output logic               out_valid,
  input  logic               out_stall,
  output dnd_pkg::out_word_t out_word
);
  import dnd_pkg::*;

  localparam int AW = $clog2(MSG_BYTES);
  localparam int LW = $clog2(MSG_BYTES + 1);
  localparam int NW = $clog2(NAME_BYTES);
  localparam int PW = PTR_W;

  localparam logic [3:0] S_IDLE = 4'd0, S_RDLEN = 4'd1, S_LEN = 4'd2, S_PTR = 4'd3,
                         S_CPRD = 4'd4, S_CPWR = 4'd5, S_DOT = 4'd6, S_EMSET = 4'd7,
                         S_EMRD = 4'd8, S_EMCAP = 4'd9, S_EMOUT = 4'd10, S_ERR = 4'd11;

  logic [7:0] msg_mem [MSG_BYTES];
  logic [7:0] name_mem [NAME_BYTES];
  logic [7:0] m_rd, n_rd;
  logic [AW-1:0] m_raddr, m_waddr;
  logic          m_we;
  logic [NW-1:0] n_raddr, n_waddr;
  logic          n_we;
  logic [7:0]    n_wd;

  logic [3:0]    state_r, state_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [8:0]    outpos_r, outpos_nxt;
  logic [LW:0]   jumps_r, jumps_nxt;
  logic          jumped_r, jumped_nxt;
  logic [PW:0]   next_r, next_nxt;
  logic [5:0]    hi_r, hi_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic [8:0]    nlen_r, nlen_nxt;
  logic [8:0]    idx_r, idx_nxt;
  logic [3:0]    ci_r, ci_nxt;
  logic [3:0]    ccnt_r, ccnt_nxt;
  logic [63:0]   chars_r, chars_nxt;
  logic [LW-1:0] msglen_r, msglen_nxt;
  logic [LW-1:0] ldpos_r, ldpos_nxt;
  logic          ov_r, ov_nxt;
  out_word_t     ow_r, ow_nxt;

  logic [8:0]    lim;
  logic [8:0]    rem;
  logic          out_free;
  logic [PW:0]   pos_ext, msglen_ext;
  logic [9:0]    room;

  assign lim        = (max_len > 9'(NAME_BYTES)) ? 9'(NAME_BYTES) : max_len;
  assign out_free   = !ov_r || !out_stall;
  assign pos_ext    = {1'b0, pos_r};
  assign msglen_ext = (PW + 1)'(msglen_r);
  assign rem        = nlen_r - idx_r;
  assign room       = {1'b0, outpos_r} + {4'b0, m_rd[5:0]} + 10'd1;
  assign out_valid  = ov_r;
  assign out_word   = ow_r;

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    outpos_nxt = outpos_r;
    jumps_nxt  = jumps_r;
    jumped_nxt = jumped_r;
    next_nxt   = next_r;
    hi_nxt     = hi_r;
    cnt_nxt    = cnt_r;
    nlen_nxt   = nlen_r;
    idx_nxt    = idx_r;
    ci_nxt     = ci_r;
    ccnt_nxt   = ccnt_r;
    chars_nxt  = chars_r;
    msglen_nxt = msglen_r;
    ldpos_nxt  = ldpos_r;
    ov_nxt     = ov_r && out_stall;
    ow_nxt     = ow_r;
    q_pop      = 1'b0;
    m_raddr    = pos_r[AW-1:0];
    m_waddr    = ldpos_r[AW-1:0];
    m_we       = 1'b0;
    n_raddr    = idx_r[NW-1:0];
    n_waddr    = outpos_r[NW-1:0];
    n_we       = 1'b0;
    n_wd       = m_rd;
    unique case (state_r)
      S_IDLE: begin
        if (q.vld) begin
          q_pop = 1'b1;
          if (q.word.func == FUNC_LOAD) begin
            if (ldpos_r < LW'(MSG_BYTES)) begin
              m_we      = 1'b1;
              ldpos_nxt = ldpos_r + 1'b1;
            end
            if (q.word.last_byte) begin
              msglen_nxt = (ldpos_r < LW'(MSG_BYTES)) ? ldpos_r + 1'b1 : ldpos_r;
              ldpos_nxt  = '0;
            end
          end else begin
            pos_nxt    = PW'(q.word.start_offset);
            outpos_nxt = '0;
            jumps_nxt  = '0;
            jumped_nxt = 1'b0;
            next_nxt   = '0;
            state_nxt  = S_RDLEN;
          end
        end
      end
      S_RDLEN: begin
        state_nxt = (pos_ext >= msglen_ext) ? S_ERR : S_LEN;
      end
      S_LEN: begin
        if ((m_rd & PTR_MARK) == PTR_MARK) begin
          m_raddr = AW'(pos_r + 1'b1);
          if (pos_ext + 1'b1 >= msglen_ext) begin
            state_nxt = S_ERR;
          end else begin
            if (!jumped_r) next_nxt = pos_ext + 2'd2;
            jumped_nxt = 1'b1;
            hi_nxt     = m_rd[5:0];
            state_nxt  = S_PTR;
          end
        end else if ((m_rd & PTR_MARK) != 8'd0) begin
          state_nxt = S_ERR;
        end else if (m_rd == 8'd0) begin
          if (!jumped_r) next_nxt = pos_ext + 1'b1;
          if (outpos_r == 9'd0) begin
            if (lim < 9'd2) begin
              state_nxt = S_ERR;
            end else begin
              n_we      = 1'b1;
              n_waddr   = '0;
              n_wd      = DOT_CHAR;
              nlen_nxt  = 9'd1;
              idx_nxt   = '0;
              state_nxt = S_EMSET;
            end
          end else begin
            nlen_nxt  = outpos_r - 1'b1;
            idx_nxt   = '0;
            state_nxt = S_EMSET;
          end
        end else begin
          if (pos_ext + 1'b1 + (PW + 1)'(m_rd[5:0]) > msglen_ext) begin
            state_nxt = S_ERR;
          end else if (room >= {1'b0, lim}) begin
            state_nxt = S_ERR;
          end else begin
            pos_nxt   = pos_r + 1'b1;
            cnt_nxt   = m_rd[5:0];
            state_nxt = S_CPRD;
          end
        end
      end
      S_PTR: begin
        pos_nxt   = {hi_r, m_rd};
        jumps_nxt = jumps_r + 1'b1;
        state_nxt = (jumps_r + 1'b1 > (LW + 1)'(msglen_r)) ? S_ERR : S_RDLEN;
      end
      S_CPRD: begin
        pos_nxt   = pos_r + 1'b1;
        cnt_nxt   = cnt_r - 1'b1;
        state_nxt = S_CPWR;
      end
      S_CPWR: begin
        n_we       = 1'b1;
        outpos_nxt = outpos_r + 1'b1;
        state_nxt  = (cnt_r == 6'd0) ? S_DOT : S_CPRD;
      end
      S_DOT: begin
        n_we       = 1'b1;
        n_wd       = DOT_CHAR;
        outpos_nxt = outpos_r + 1'b1;
        state_nxt  = S_RDLEN;
      end
      S_EMSET: begin
        ccnt_nxt  = (rem > 9'd8) ? 4'd8 : rem[3:0];
        ci_nxt    = '0;
        chars_nxt = '0;
        state_nxt = S_EMRD;
      end
      S_EMRD: begin
        state_nxt = S_EMCAP;
      end
      S_EMCAP: begin
        chars_nxt[{ci_r[2:0], 3'b000} +: 8] = n_rd;
        ci_nxt    = ci_r + 1'b1;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = (ci_r + 1'b1 == ccnt_r) ? S_EMOUT : S_EMRD;
      end
      S_EMOUT: begin
        if (out_free) begin
          ov_nxt             = 1'b1;
          ow_nxt.name_chars  = chars_r;
          ow_nxt.char_count  = ccnt_r;
          ow_nxt.last_chunk  = (idx_r == nlen_r);
          ow_nxt.status      = 1'b0;
          ow_nxt.next_offset = next_r[9:0];
          state_nxt          = (idx_r == nlen_r) ? S_IDLE : S_EMSET;
        end
      end
      S_ERR: begin
        if (out_free) begin
          ov_nxt             = 1'b1;
          ow_nxt.name_chars  = '0;
          ow_nxt.char_count  = '0;
          ow_nxt.last_chunk  = 1'b1;
          ow_nxt.status      = 1'b1;
          ow_nxt.next_offset = '0;
          state_nxt          = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      msglen_r <= '0;
      ldpos_r  <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      msglen_r <= msglen_nxt;
      ldpos_r  <= ldpos_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    outpos_r <= outpos_nxt;
    jumps_r  <= jumps_nxt;
    jumped_r <= jumped_nxt;
    next_r   <= next_nxt;
    hi_r     <= hi_nxt;
    cnt_r    <= cnt_nxt;
    nlen_r   <= nlen_nxt;
    idx_r    <= idx_nxt;
    ci_r     <= ci_nxt;
    ccnt_r   <= ccnt_nxt;
    chars_r  <= chars_nxt;
    ow_r     <= ow_nxt;
  end

  always_ff @(posedge clk) begin
    if (m_we) msg_mem[m_waddr] <= q.word.data_byte;
    m_rd <= msg_mem[m_raddr];
  end

  always_ff @(posedge clk) begin
    if (n_we) name_mem[n_waddr] <= n_wd;
    n_rd <= name_mem[n_raddr];
  end

endmodule

@@ bench/dnd_checker.sv @@
module dnd_checker
  import dnd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_word,
  input  logic      cfg_we,
  input  logic [8:0] cfg_wdata,
  output int        fail_count,
  output int        chunks_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MSG_BYTES  = 512;
  localparam int NAME_BYTES = 256;

  logic [7:0] msg_mem [MSG_BYTES];
  logic [7:0] name_buf [NAME_BYTES];
  int         msg_len;
  int         load_pos;
  int         max_name;
  out_word_t  chunk_q [$];

  assign chunks_due = chunk_q.size();

  // returns name length, 0 on any malformed/looping/too-long name
  function automatic int decode_name(input int start, output int nxt);
    int pos, outp, jumps, lim, len;
    bit jumped;
    logic [7:0] b;
    nxt = 0;
    outp = 0;
    jumps = 0;
    jumped = 0;
    pos = start;
    lim = (max_name > NAME_BYTES) ? NAME_BYTES : max_name;
    while (pos < msg_len) begin
      b = msg_mem[pos];
      len = int'(b);
      if ((b & PTR_MARK) == PTR_MARK) begin
        if (pos + 1 >= msg_len) return 0;
        if (!jumped) nxt = pos + 2;
        jumped = 1;
        pos = int'({b[5:0], msg_mem[pos+1]});
        jumps++;
        if (jumps > msg_len) return 0;
        continue;
      end
      if ((b & PTR_MARK) != 8'h00) return 0;
      if (len == 0) begin
        if (!jumped) nxt = pos + 1;
        if (outp == 0) begin
          if (lim < 2) return 0;
          name_buf[0] = DOT_CHAR;
          return 1;
        end
        return outp - 1;
      end
      pos++;
      if (pos + len > msg_len) return 0;
      if (outp + len + 1 >= lim) return 0;
      for (int i = 0; i < len; i++) name_buf[outp+i] = msg_mem[pos+i];
      outp += len;
      name_buf[outp] = DOT_CHAR;
      outp++;
      pos += len;
    end
    return 0;
  endfunction

  task automatic predict_decode(input int start);
    int nlen, nxt, nchunks, cnt;
    out_word_t w;
    nlen = decode_name(start, nxt);
    if (nlen == 0) begin
      w = '0;
      w.last_chunk = 1'b1;
      w.status = 1'b1;
      chunk_q.push_back(w);
    end else begin
      nchunks = (nlen + 7) / 8;
      for (int k = 0; k < nchunks; k++) begin
        w = '0;
        cnt = nlen - k * 8;
        if (cnt > 8) cnt = 8;
        for (int i = 0; i < cnt; i++) w.name_chars[8*i +: 8] = name_buf[k*8 + i];
        w.char_count = 4'(cnt);
        w.last_chunk = (k + 1 == nchunks);
        w.status = 1'b0;
        w.next_offset = 10'(nxt);
        chunk_q.push_back(w);
      end
    end
  endtask

  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      msg_len = 0;
      load_pos = 0;
      max_name = 256;
      chunk_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) max_name = int'(cfg_wdata);
      if (in_valid && !in_stall) begin
        if (in_word.func == FUNC_LOAD) begin
          if (load_pos < MSG_BYTES) begin
            msg_mem[load_pos] = in_word.data_byte;
            load_pos++;
          end
          if (in_word.last_byte) begin
            msg_len = load_pos;
            load_pos = 0;
          end
        end else begin
          predict_decode(int'(in_word.start_offset));
        end
      end
      if (out_valid && !out_stall) begin
        if (chunk_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected word: %h", out_word);
        end else begin
          e = chunk_q.pop_front();
          if (e.name_chars !== out_word.name_chars ||
              e.char_count !== out_word.char_count ||
              e.last_chunk !== out_word.last_chunk || e.status !== out_word.status ||
              e.next_offset !== out_word.next_offset) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch: exp chars %h cnt %0d last %b st %b nxt %0d",
                        " / got chars %h cnt %0d last %b st %b nxt %0d"},
                       e.name_chars, e.char_count, e.last_chunk, e.status,
                       e.next_offset, out_word.name_chars, out_word.char_count,
                       out_word.last_chunk, out_word.status, out_word.next_offset);
          end
        end
      end
    end
  end
endmodule

@@ bench/tb_top.sv @@
module tb_top;
  import dnd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 3000000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_word_t   in_word = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_word;
  logic       cfg_we = 1'b0;
  logic [8:0] cfg_wdata = '0;
  int         fail_count;
  int         chunks_due;
  int         cycles = 0;
  int         send_idle = 21;
  int         recv_idle = 65;
  int         hold_cnt = 0;
  logic [7:0] msg_q [$];
  int         name_starts [$];

  always #5 clk = ~clk;

  dns_name_decompressor_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  dnd_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .chunks_due(chunks_due)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_stall = 1'b1;
      hold_cnt--;
    end else begin
      out_stall = ($urandom_range(99) < recv_idle);
    end
  end

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_word = w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic load_byte(input logic [7:0] b, input logic last);
    in_word_t w;
    w = '0;
    w.func = FUNC_LOAD;
    w.data_byte = b;
    w.last_byte = last;
    w.start_offset = 9'($urandom);
    send_word(w);
  endtask

  task automatic decode_at(input int off);
    in_word_t w;
    w = '0;
    w.func = FUNC_DECODE;
    w.data_byte = 8'($urandom);
    w.last_byte = 1'($urandom);
    w.start_offset = 9'(off);
    send_word(w);
  endtask

  task automatic load_message();
    foreach (msg_q[i]) load_byte(msg_q[i], i == msg_q.size() - 1);
  endtask

  task automatic write_max_name(input logic [8:0] v);
    in_valid = 1'b0;
    while (chunks_due != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic add_name(input int nlab, input int maxlab);
    int len, tgt;
    name_starts.push_back(msg_q.size());
    for (int l = 0; l < nlab; l++) begin
      len = ($urandom_range(11) == 0) ? 63 : $urandom_range(maxlab, 1);
      msg_q.push_back(8'(len));
      for (int i = 0; i < len; i++) msg_q.push_back(8'($urandom));
    end
    if (name_starts.size() > 1 && $urandom_range(2) == 0) begin
      tgt = name_starts[$urandom_range(name_starts.size() - 2)];
      if ($urandom_range(9) == 0) tgt = $urandom_range(16383);
      msg_q.push_back(PTR_MARK | tgt[13:8]);
      msg_q.push_back(tgt[7:0]);
    end else begin
      msg_q.push_back(8'h00);
    end
  endtask

  task automatic build_message(input int nnames);
    int p;
    msg_q.delete();
    name_starts.delete();
    for (int n = 0; n < nnames; n++) add_name($urandom_range(3), 6);
    if ($urandom_range(3) == 0) begin
      p = $urandom_range(msg_q.size() - 1);
      msg_q[p] = 8'($urandom);
    end
    if ($urandom_range(4) == 0) msg_q.push_back(PTR_MARK);
  endtask

  task automatic decode_message();
    foreach (name_starts[i]) decode_at(name_starts[i]);
    decode_at($urandom_range(msg_q.size() - 1));
    decode_at($urandom_range(511));
  endtask

  task automatic random_round(input int nmsgs);
    for (int m = 0; m < nmsgs; m++) begin
      build_message($urandom_range(5, 2));
      load_message();
      decode_message();
    end
  endtask

  initial begin
    logic [7:0] dmsg [$];
    int dstarts [$];
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // empty message, then a small hand-built message
    decode_at(0);
    dmsg = '{8'h00, 8'h03, "a", "b", "c", 8'h00, 8'hc0, 8'h01, 8'h40, 8'h80,
             8'hc1, 8'hff, 8'hc0, 8'h0c, 8'h05, "x"};
    msg_q = dmsg;
    load_message();
    dstarts = '{0, 1, 6, 8, 9, 10, 12, 14, 511};
    foreach (dstarts[i]) decode_at(dstarts[i]);
    write_max_name(9'd2);
    decode_at(0);
    decode_at(1);
    write_max_name(9'd256);

    random_round(1);

    send_idle = 65;
    recv_idle = 21;
    write_max_name(9'($urandom_range(60, 10)));
    random_round(1);

    send_idle = 0;
    recv_idle = 0;
    write_max_name(9'd256);
    hold_cnt = 600;
    random_round(1);

    in_valid = 1'b0;
    while (chunks_due != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
